// ----- rtl/rse_pkg.sv -----
// ---------------------------------------------------------------------------
// rse_pkg
// Shared types and constants for the postfix expression evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

package rse_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
	localparam logic [1:0] ERR_DIVZERO   = 2'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QAW         = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic        push_en;
		logic [31:0] push_val;
		op_t         op;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_PUSH,
		BS_OPRD,
		BS_EXEC,
		BS_MUL,
		BS_DIV,
		BS_DFIX,
		BS_FIN
	} back_state_t;

endpackage

`default_nettype wire

// ----- rtl/rse_ram.sv -----
// ---------------------------------------------------------------------------
// rse_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module rse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/rse_front.sv -----
// ---------------------------------------------------------------------------
// rse_front
// Accepts characters, builds decimal numbers and issues stack commands.
// ---------------------------------------------------------------------------
`default_nettype none

module rse_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       char_code,
	input  wire logic             end_of_expression,
	input  wire rse_pkg::q_status_t q_stat,
	output logic                  q_wr,
	output rse_pkg::cmd_t         q_wdata
);

	import rse_pkg::*;

	logic [31:0] acc_q;
	logic        in_num_q;
	logic        is_digit;
	logic [7:0]  dig_full;
	logic [31:0] acc_next;
	logic        accept;

	assign is_digit = char_code inside {[CH_ZERO:CH_NINE]};
	assign dig_full = char_code - CH_ZERO;
	assign acc_next = (acc_q << 3) + (acc_q << 1) + {28'd0, dig_full[3:0]};
	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;

	always_comb begin
		q_wdata.push_en  = is_digit ? end_of_expression : in_num_q;
		q_wdata.push_val = is_digit ? acc_next : acc_q;
		q_wdata.last     = end_of_expression;
		case (char_code)
			CH_PLUS:  q_wdata.op = OP_ADD;
			CH_MINUS: q_wdata.op = OP_SUB;
			CH_STAR:  q_wdata.op = OP_MUL;
			CH_SLASH: q_wdata.op = OP_DIV;
			default:  q_wdata.op = OP_NONE;
		endcase
		q_wr = accept && (q_wdata.push_en || (q_wdata.op != OP_NONE) || end_of_expression);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			in_num_q <= 1'b0;
		end else if (accept) begin
			if (is_digit && !end_of_expression) begin
				acc_q    <= acc_next;
				in_num_q <= 1'b1;
			end else begin
				acc_q    <= '0;
				in_num_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rse_queue.sv -----
// ---------------------------------------------------------------------------
// rse_queue
// Small command queue between the front and the stack engine.
// ---------------------------------------------------------------------------
`default_nettype none

module rse_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr,
	input  wire rse_pkg::cmd_t        wdata,
	input  wire logic                 rd,
	output rse_pkg::cmd_t             rdata,
	output rse_pkg::q_status_t        stat
);

	import rse_pkg::*;

	cmd_t           mem_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == (QAW+1)'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + (QAW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QAW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/rse_back.sv -----
// ---------------------------------------------------------------------------
// rse_back
// Stack engine: push, arithmetic with an iterative divider, final result.
// ---------------------------------------------------------------------------
`default_nettype none

module rse_back #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rse_pkg::q_status_t    q_stat,
	input  wire rse_pkg::cmd_t         q_rdata,
	output logic                       q_rd,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [31:0]         value,
	output logic        [1:0]          status
);

	import rse_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	back_state_t state_q, state_d;
	cmd_t        cmd_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [1:0]  err_q;
	logic [31:0] top_q;
	logic [31:0] prod_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic [4:0]  it_q;
	logic        out_valid_q;
	logic [31:0] value_q;
	logic [1:0]  status_q;

	logic        ram_we;
	logic [31:0] second;
	logic        push_ok;
	logic        out_free;
	logic [32:0] shifted;
	logic        fits;
	logic [31:0] mag_a;
	logic [31:0] mag_b;

	assign cnt_m1   = cnt_q - CW'(1);
	assign cnt_m2   = cnt_q - CW'(2);
	assign push_ok  = cnt_q < CW'(STACK_DEPTH);
	assign out_free = !out_valid_q || !out_stall;
	assign ram_we   = (state_q == BS_PUSH) && cmd_q.push_en && (err_q == ERR_NONE)
		&& push_ok && (cnt_q != '0);
	assign shifted  = {rem_q, quo_q[31]};
	assign fits     = shifted >= {1'b0, dvs_q};
	assign mag_a    = second[31] ? (32'd0 - second) : second;
	assign mag_b    = top_q[31] ? (32'd0 - top_q) : top_q;

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	rse_ram #(
		.WIDTH (32),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_m1[AW-1:0]),
		.wdata (top_q),
		.raddr (cnt_m2[AW-1:0]),
		.rdata (second)
	);

	always_comb begin
		state_d = state_q;
		q_rd    = 1'b0;
		case (state_q)
			BS_IDLE: begin
				if (!q_stat.empty) begin
					q_rd    = 1'b1;
					state_d = BS_PUSH;
				end
			end
			BS_PUSH: begin
				state_d = (cmd_q.op != OP_NONE) ? BS_OPRD : BS_FIN;
			end
			BS_OPRD: begin
				state_d = ((err_q != ERR_NONE) || (cnt_q < CW'(2))) ? BS_FIN : BS_EXEC;
			end
			BS_EXEC: begin
				case (cmd_q.op)
					OP_MUL:  state_d = BS_MUL;
					OP_DIV:  state_d = (top_q == '0) ? BS_FIN : BS_DIV;
					default: state_d = BS_FIN;
				endcase
			end
			BS_MUL: begin
				state_d = BS_FIN;
			end
			BS_DIV: begin
				if (it_q == '0) begin
					state_d = BS_DFIX;
				end
			end
			BS_DFIX: begin
				state_d = BS_FIN;
			end
			BS_FIN: begin
				if (!cmd_q.last || out_free) begin
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_IDLE;
			cnt_q       <= '0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == BS_FIN) && cmd_q.last && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BS_PUSH: begin
					if (cmd_q.push_en && (err_q == ERR_NONE)) begin
						if (push_ok) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							err_q <= ERR_OVERFLOW;
						end
					end
				end
				BS_OPRD: begin
					if ((err_q == ERR_NONE) && (cnt_q < CW'(2))) begin
						err_q <= ERR_UNDERFLOW;
					end
				end
				BS_EXEC: begin
					if ((cmd_q.op == OP_ADD) || (cmd_q.op == OP_SUB)) begin
						cnt_q <= cnt_m1;
					end else if ((cmd_q.op == OP_DIV) && (top_q == '0)) begin
						err_q <= ERR_DIVZERO;
					end
				end
				BS_MUL, BS_DFIX: begin
					cnt_q <= cnt_m1;
				end
				BS_FIN: begin
					if (cmd_q.last && out_free) begin
						cnt_q <= '0;
						err_q <= ERR_NONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			BS_IDLE: begin
				if (!q_stat.empty) begin
					cmd_q <= q_rdata;
				end
			end
			BS_PUSH: begin
				if (cmd_q.push_en && (err_q == ERR_NONE) && push_ok) begin
					top_q <= cmd_q.push_val;
				end
			end
			BS_EXEC: begin
				case (cmd_q.op)
					OP_ADD: top_q  <= second + top_q;
					OP_SUB: top_q  <= second - top_q;
					OP_MUL: prod_q <= second * top_q;
					OP_DIV: begin
						rem_q <= '0;
						quo_q <= mag_a;
						dvs_q <= mag_b;
						neg_q <= second[31] ^ top_q[31];
						it_q  <= 5'd31;
					end
					default: begin
					end
				endcase
			end
			BS_MUL: begin
				top_q <= prod_q;
			end
			BS_DIV: begin
				if (fits) begin
					rem_q <= shifted[31:0] - dvs_q;
				end else begin
					rem_q <= shifted[31:0];
				end
				quo_q <= {quo_q[30:0], fits};
				it_q  <= it_q - 5'd1;
			end
			BS_DFIX: begin
				top_q <= neg_q ? (32'd0 - quo_q) : quo_q;
			end
			BS_FIN: begin
				if (cmd_q.last && out_free) begin
					if (err_q != ERR_NONE) begin
						status_q <= err_q;
						value_q  <= '0;
					end else if (cnt_q == '0) begin
						status_q <= ERR_UNDERFLOW;
						value_q  <= '0;
					end else begin
						status_q <= ERR_NONE;
						value_q  <= top_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/rpn_stack_evaluator_top.sv -----
// ---------------------------------------------------------------------------
// rpn_stack_evaluator_top
// Postfix expression evaluator: character front end, command queue, stack
// engine with an iterative 32-bit divider.
// ---------------------------------------------------------------------------
// digits that do not end an expression only build a number in the front end
// pushes, operators and ends of expression go as commands to the stack engine
// (the radix-2 divider runs 32 iterations); the engine takes one at a time
// the result is presented once the last request is done and the output is free
// reset clears all control state; stack entries are undefined until pushed
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_stack_evaluator_top #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         char_code,
	input  wire logic               end_of_expression,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      value,
	output logic        [1:0]       status
);

	import rse_pkg::*;

	q_status_t q_stat;
	logic      q_wr;
	logic      q_rd;
	cmd_t      q_wdata;
	cmd_t      q_rdata;

	rse_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.char_code         (char_code),
		.end_of_expression (end_of_expression),
		.q_stat            (q_stat),
		.q_wr              (q_wr),
		.q_wdata           (q_wdata)
	);

	rse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	rse_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_rdata   (q_rdata),
		.q_rd      (q_rd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.status    (status)
	);

	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ERR_NONE) |-> (value == 32'sd0))
		else $error("error result carries a nonzero value");

	a_no_queue_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !q_stat.full)
		else $error("command written into a full queue");

	a_no_queue_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !q_stat.empty)
		else $error("command read from an empty queue");

endmodule

`default_nettype wire

// ----- verif/tb_rpn_stack_evaluator_top.sv -----
// ---------------------------------------------------------------------------
// tb_rpn_stack_evaluator_top
// Self-checking bench for the postfix expression evaluator. A queue of
// character requests (directed expressions, then random well-formed, deep,
// corner and broken ones) feeds a clocked driver with random gaps. The
// driver steps a behavioral evaluator on every accepted request, and a
// clocked monitor with random stalls compares each result with the oldest
// predicted answer. A watchdog ends the run if the traffic stops.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_rpn_stack_evaluator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rse_pkg::*;

	localparam int DEPTH = 64;
	localparam int N_ITEMS = 1850;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 2500;
	localparam int HOLD_AT_RESULT = 15;
	localparam int DRAIN_CYCLES = 80;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} char_req_t;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         status;
	} answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         char_code = 8'd0;
	logic               end_of_expression = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] value;
	logic [1:0]         status;

	char_req_t char_q[$];
	answer_t   answer_q[$];
	int        n_items = 0;
	int        n_errors = 0;
	int        n_results = 0;

	// evaluator state
	logic [31:0] opnd_stack [DEPTH];
	int unsigned opnd_count = 0;
	logic [31:0] num_acc = '0;
	bit          num_open = 1'b0;
	logic [1:0]  sticky_err = ERR_NONE;

	rpn_stack_evaluator_top #(
		.STACK_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.end_of_expression(end_of_expression),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value),
		.status(status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_op(logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
	endfunction

	function void push_operand(logic [31:0] v);
		if (sticky_err != ERR_NONE)
			return;
		if (opnd_count >= DEPTH) begin
			sticky_err = ERR_OVERFLOW;
			return;
		end
		opnd_stack[opnd_count] = v;
		opnd_count++;
	endfunction

	function void close_number();
		if (num_open) begin
			push_operand(num_acc);
			num_acc = '0;
			num_open = 1'b0;
		end
	endfunction

	function automatic logic [31:0] div_toward_zero(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function void apply_operator(logic [7:0] c);
		logic [31:0] rhs;
		logic [31:0] lhs;
		logic [31:0] r;
		if (sticky_err != ERR_NONE)
			return;
		if (opnd_count < 2) begin
			sticky_err = ERR_UNDERFLOW;
			return;
		end
		rhs = opnd_stack[opnd_count - 1];
		lhs = opnd_stack[opnd_count - 2];
		opnd_count -= 2;
		case (c)
			CH_PLUS: r = lhs + rhs;
			CH_MINUS: r = lhs - rhs;
			CH_STAR: r = lhs * rhs;
			default: begin
				if (rhs == 0) begin
					sticky_err = ERR_DIVZERO;
					return;
				end
				r = div_toward_zero(lhs, rhs);
			end
		endcase
		push_operand(r);
	endfunction

	function void evaluate_char(logic [7:0] c, logic last);
		answer_t a;
		if (is_digit(c)) begin
			num_acc = num_acc * 32'd10 + 32'(c - CH_ZERO);
			num_open = 1'b1;
		end else begin
			close_number();
			if (is_op(c))
				apply_operator(c);
		end
		if (!last)
			return;
		close_number();
		a.value = '0;
		a.status = sticky_err;
		if (sticky_err == ERR_NONE) begin
			if (opnd_count == 0)
				a.status = ERR_UNDERFLOW;
			else
				a.value = opnd_stack[opnd_count - 1];
		end
		answer_q.push_back(a);
		opnd_count = 0;
		num_acc = '0;
		num_open = 1'b0;
		sticky_err = ERR_NONE;
	endfunction

	// ---- stimulus builders

	task automatic put_char(logic [7:0] c, logic last);
		char_req_t r;
		r.ch = c;
		r.last = last;
		char_q.push_back(r);
		n_items++;
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] rand_noise();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (is_digit(c) || is_op(c));
		return c;
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(0, 3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	task automatic put_sep();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 3) : 1;
		repeat (n)
			put_char(($urandom_range(0, 3) == 0) ? rand_noise() : CH_SPACE, 1'b0);
	endtask

	task automatic put_number();
		string s;
		int k;
		k = $urandom_range(0, 99);
		if (k < 35)
			s = $sformatf("%0d", $urandom_range(0, 9));
		else if (k < 60)
			s = $sformatf("%0d", $urandom_range(0, 999));
		else if (k < 80)
			s = $sformatf("%0d", $urandom());
		else if (k < 90) begin
			case ($urandom_range(0, 4))
				0: s = "2147483648";
				1: s = "2147483647";
				2: s = "4294967295";
				3: s = "0";
				default: s = "1";
			endcase
		end else begin
			s = "";
			repeat ($urandom_range(11, 14))
				s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
		end
		for (int i = 0; i < s.len(); i++)
			put_char(s[i], 1'b0);
	endtask

	// well-formed postfix body with n operands, eoe not set
	task automatic put_expr_body(int n);
		int depth;
		int left;
		bit prev_num;
		depth = 0;
		left = n;
		prev_num = 1'b0;
		while (left > 0 || depth > 1) begin
			if (depth < 2 || (left > 0 && $urandom_range(0, 1) == 1)) begin
				if (prev_num)
					put_sep();
				put_number();
				depth++;
				left--;
				prev_num = 1'b1;
			end else begin
				if ($urandom_range(0, 3) == 0)
					put_sep();
				put_char(rand_op(), 1'b0);
				depth--;
				prev_num = 1'b0;
			end
		end
	endtask

	task automatic end_expr();
		if ($urandom_range(0, 2) == 0)
			put_char(($urandom_range(0, 1) == 1) ? CH_SPACE : rand_noise(), 1'b1);
		else
			char_q[$].last = 1'b1;
	endtask

	task automatic put_random_expr();
		int k;
		int n;
		k = $urandom_range(0, 99);
		if (k < 55) begin
			put_expr_body($urandom_range(1, 10));
			end_expr();
		end else if (k < 65) begin
			// entries left below the top are discarded
			repeat ($urandom_range(1, 3)) begin
				put_number();
				put_sep();
			end
			put_expr_body($urandom_range(1, 6));
			end_expr();
		end else if (k < 67) begin
			n = $urandom_range(60, 70);
			repeat (n) begin
				put_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
				put_char(CH_SPACE, 1'b0);
			end
			repeat (n - 1)
				put_char(rand_op(), 1'b0);
			end_expr();
		end else if (k < 77) begin
			case ($urandom_range(0, 6))
				0: put_text("2147483648 0 1-/");
				1: put_text("0 2147483648-1-");
				2: put_text("4294967295 4294967295*");
				3: put_text("7 0 2-/");
				4: put_text("5 0/3+");
				5: put_text("9 9 9 9 9 9 9 9 9 9 9 9");
				default: put_text("1 2+++");
			endcase
		end else if (k < 85) begin
			put_expr_body($urandom_range(1, 5));
			put_char(rand_op(), 1'b0);
			end_expr();
		end else begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 3))
					0: put_char(8'(CH_ZERO + $urandom_range(0, 9)), i == n - 1);
					1: put_char(rand_op(), i == n - 1);
					2: put_char(CH_SPACE, i == n - 1);
					default: put_char(rand_noise(), i == n - 1);
				endcase
			end
		end
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// ---- request driver

	int unsigned gap_left = 0;
	int unsigned calm_in = 0;

	always @(posedge clk) begin
		logic nv;
		if (arst_n) begin
			nv = in_valid;
			if (in_valid && !in_stall) begin
				evaluate_char(char_code, end_of_expression);
				void'(char_q.pop_front());
				nv = 1'b0;
				if (calm_in > 0) begin
					calm_in--;
					gap_left = 0;
				end else begin
					gap_left = pick_gap();
					if ($urandom_range(0, 99) == 0)
						calm_in = 150;
				end
			end
			if (!nv) begin
				if (gap_left > 0)
					gap_left--;
				else if (char_q.size() > 0) begin
					nv = 1'b1;
					char_code <= char_q[0].ch;
					end_of_expression <= char_q[0].last;
				end
			end
			in_valid <= nv;
		end
	end

	// ---- result monitor

	int unsigned stall_run = 0;
	int unsigned hold_left = 0;

	always @(posedge clk) begin
		logic ns;
		answer_t a;
		if (arst_n) begin
			ns = out_stall;
			if (out_valid === 1'b1 && !out_stall) begin
				n_results++;
				if (answer_q.size() == 0) begin
					n_errors++;
					$display("%0t unexpected result: value %0d status %0d",
						$time, value, status);
				end else begin
					a = answer_q.pop_front();
					if (value !== a.value) begin
						n_errors++;
						$display("%0t value mismatch: expected %0d, actual %0d",
							$time, a.value, value);
					end
					if (status !== a.status) begin
						n_errors++;
						$display("%0t status mismatch: expected %0d, actual %0d",
							$time, a.status, status);
					end
				end
				// long hold-off so the block backs up into its request side
				if (n_results == HOLD_AT_RESULT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ns = 1'b1;
			end else if (stall_run > 0) begin
				stall_run--;
			end else begin
				if ($urandom_range(0, 99) < 3) begin
					ns = 1'b0;
					stall_run = 300;
				end else if ($urandom_range(0, 99) < 35) begin
					ns = 1'b1;
					stall_run = pick_gap();
				end else begin
					ns = 1'b0;
					stall_run = $urandom_range(1, 20);
				end
			end
			out_stall <= ns;
		end
	end

	// ---- watchdog

	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t watchdog: no request or result accepted", $time);
			$display("** rpn_stack_evaluator_top: FAILED **");
			$finish;
		end
	end

	// ---- sequence

	initial begin
		// directed: single digit, empty stack, lone operator, every operator,
		// divide by zero, negative truncating division
		put_text("5");
		put_text(" ");
		put_text("+");
		put_text("9 4-3*2/7+");
		put_text("6 0/");
		put_text("0 7-2/");
		while (n_items < N_ITEMS)
			put_random_expr();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (char_q.size() != 0 || in_valid || answer_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_errors == 0 && answer_q.size() == 0)
			$display("** rpn_stack_evaluator_top: PASSED **");
		else
			$display("** rpn_stack_evaluator_top: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
